FILE: rtl/sec_usec_time_alu_unit_assert.svh
// Assertion macros for the time ALU.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef SEC_USEC_TIME_ALU_UNIT_ASSERT_SVH
`define SEC_USEC_TIME_ALU_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SUTALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define SUTALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define SUTALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SUTALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/sutalu_pkg.sv
package sutalu_pkg;

    // time value: wrapped seconds plus microseconds
    typedef struct packed {
        logic [31:0] s;
        logic [19:0] u;
    } t_tval;

    // operation codes
    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SUB  = 3'd1;
    localparam logic [2:0] KIND_CMP  = 3'd2;
    localparam logic [2:0] KIND_MUL  = 3'd3;
    localparam logic [2:0] KIND_DIV  = 3'd4;
    localparam logic [2:0] KIND_DIFF = 3'd5;

    // compare answers
    localparam logic [1:0] ORDER_EQ = 2'd0;
    localparam logic [1:0] ORDER_GT = 2'd1;
    localparam logic [1:0] ORDER_LT = 2'd2;

    localparam logic [19:0] US_PER_SEC   = 20'd1000000;
    localparam logic [20:0] US_PER_SEC_W = 21'd1000000;

    // divider step counts; narrow dividends sit left-aligned in the word
    localparam logic [5:0] DIV_STEPS_WIDE   = 6'd32;
    localparam logic [5:0] DIV_STEPS_NARROW = 6'd20;
    localparam int         DIV_PAD          = 12;

    // divider command and response
    typedef struct packed {
        logic        start;
        logic [5:0]  steps;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

FILE: rtl/sec_usec_time_alu_unit.sv
// Add, subtract, compare, difference, unknown kinds and a zero divide post their result
// from the execute state; multiply takes an add and a doubling step per significant bit
// of |factor|; divide runs the divider three times (32+20+20 divider steps).
// One word in flight at a time: busy stays high until the result strobe.
// The strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
`include "sec_usec_time_alu_unit_assert.svh"

module sec_usec_time_alu_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_a_sec,
    input  logic [19:0]        i_a_usec,
    input  logic signed [31:0] i_b_sec,
    input  logic [19:0]        i_b_usec,
    input  logic signed [31:0] i_factor,
    output logic               o_done,
    output logic signed [31:0] o_r_sec,
    output logic [19:0]        o_r_usec,
    output logic [1:0]         o_order,
    output logic               o_fits_small,
    output logic               o_div_zero
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EXEC    = 8'b0000_0010,
        S_MUL_ADD = 8'b0000_0100,
        S_MUL_DBL = 8'b0000_1000,
        S_DIV     = 8'b0001_0000,
        S_DIV_MUL = 8'b0010_0000,
        S_DIV_SUM = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_kind, n_kind;
    sutalu_pkg::t_tval r_a, n_a;
    sutalu_pkg::t_tval r_b, n_b;
    logic [31:0]       r_fac, n_fac;
    sutalu_pkg::t_tval r_acc, n_acc;
    sutalu_pkg::t_tval r_cur, n_cur;
    logic [31:0]       r_m, n_m;
    logic              r_neg, n_neg;
    logic [19:0]       r_tu, n_tu;
    logic [31:0]       r_qs, n_qs;
    logic [19:0]       r_rs, n_rs;
    logic [19:0]       r_qk, n_qk;
    logic [19:0]       r_qu, n_qu;
    logic [19:0]       r_prod, n_prod;
    logic [1:0]        r_phase, n_phase;
    logic              r_done, n_done;
    logic [31:0]       r_out_sec, n_out_sec;
    logic [19:0]       r_out_usec, n_out_usec;
    logic [1:0]        r_out_order, n_out_order;
    logic              r_out_fits, n_out_fits;
    logic              r_out_dz, n_out_dz;

    sutalu_pkg::t_tval  tadd_x;
    sutalu_pkg::t_tval  tadd_y;
    logic               tadd_sub;
    sutalu_pkg::t_tval  tadd_res;
    sutalu_pkg::t_tval  t_abs;
    sutalu_pkg::t_tval  fin_val;
    logic [31:0]        fac_mag;
    logic [39:0]        prod_full;
    sutalu_pkg::t_div_req div_req;
    sutalu_pkg::t_div_rsp div_rsp;

    // shared time adder
    sutalu_tadd u_tadd (
        .i_x   (tadd_x),
        .i_y   (tadd_y),
        .i_sub (tadd_sub),
        .o_r   (tadd_res)
    );

    // shared iterative divider
    sutalu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign fac_mag   = r_fac[31] ? (32'd0 - r_fac) : r_fac;
    assign t_abs     = r_a.s[31] ? tadd_res : r_a;
    assign fin_val   = r_neg ? tadd_res : r_acc;
    assign prod_full = r_rs * r_qk;

    // route operands into the time adder
    always_comb begin
        tadd_x   = '0;
        tadd_y   = '0;
        tadd_sub = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_kind)
                    sutalu_pkg::KIND_ADD: begin
                        tadd_x = r_a;
                        tadd_y = r_b;
                    end
                    sutalu_pkg::KIND_SUB, sutalu_pkg::KIND_DIFF: begin
                        tadd_x   = r_a;
                        tadd_y   = r_b;
                        tadd_sub = 1'b1;
                    end
                    sutalu_pkg::KIND_DIV: begin
                        tadd_y   = r_a;
                        tadd_sub = 1'b1;
                    end
                    default: begin
                        tadd_x = '0;
                    end
                endcase
            end
            S_MUL_ADD: begin
                tadd_x = r_acc;
                tadd_y = r_cur;
            end
            S_MUL_DBL: begin
                tadd_x = r_cur;
                tadd_y = r_cur;
            end
            S_FIN: begin
                tadd_y   = r_acc;
                tadd_sub = 1'b1;
            end
            default: begin
                tadd_x = '0;
            end
        endcase
    end

    // sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_a         = r_a;
        n_b         = r_b;
        n_fac       = r_fac;
        n_acc       = r_acc;
        n_cur       = r_cur;
        n_m         = r_m;
        n_neg       = r_neg;
        n_tu        = r_tu;
        n_qs        = r_qs;
        n_rs        = r_rs;
        n_qk        = r_qk;
        n_qu        = r_qu;
        n_prod      = r_prod;
        n_phase     = r_phase;
        n_done      = 1'b0;
        n_out_sec   = r_out_sec;
        n_out_usec  = r_out_usec;
        n_out_order = r_out_order;
        n_out_fits  = r_out_fits;
        n_out_dz    = r_out_dz;
        div_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_a.s   = i_a_sec;
                    n_a.u   = i_a_usec;
                    n_b.s   = i_b_sec;
                    n_b.u   = i_b_usec;
                    n_fac   = i_factor;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_sec   = '0;
                n_out_usec  = '0;
                n_out_order = sutalu_pkg::ORDER_EQ;
                n_out_fits  = 1'b0;
                n_out_dz    = 1'b0;
                case (r_kind)
                    sutalu_pkg::KIND_ADD, sutalu_pkg::KIND_SUB: begin
                        n_out_sec  = tadd_res.s;
                        n_out_usec = tadd_res.u;
                        n_done     = 1'b1;
                        n_state    = S_IDLE;
                    end
                    sutalu_pkg::KIND_DIFF: begin
                        n_out_sec  = tadd_res.s;
                        n_out_usec = tadd_res.u;
                        n_out_fits = (tadd_res.s == 32'd0);
                        n_done     = 1'b1;
                        n_state    = S_IDLE;
                    end
                    sutalu_pkg::KIND_CMP: begin
                        if (r_a.s != r_b.s) begin
                            n_out_order = ($signed(r_a.s) > $signed(r_b.s))
                                          ? sutalu_pkg::ORDER_GT : sutalu_pkg::ORDER_LT;
                        end else if (r_a.u != r_b.u) begin
                            n_out_order = (r_a.u > r_b.u)
                                          ? sutalu_pkg::ORDER_GT : sutalu_pkg::ORDER_LT;
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    sutalu_pkg::KIND_MUL: begin
                        n_acc   = '0;
                        n_cur   = r_a;
                        n_m     = fac_mag;
                        n_neg   = r_fac[31];
                        n_state = S_MUL_ADD;
                    end
                    sutalu_pkg::KIND_DIV: begin
                        if (r_fac == 32'd0) begin
                            n_out_dz = 1'b1;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            // divide magnitudes, remember the sign
                            n_neg            = r_fac[31] ^ r_a.s[31];
                            n_tu             = t_abs.u;
                            div_req.start    = 1'b1;
                            div_req.steps    = sutalu_pkg::DIV_STEPS_WIDE;
                            div_req.dividend = t_abs.s;
                            div_req.divisor  = fac_mag;
                            n_phase          = 2'd0;
                            n_state          = S_DIV;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MUL_ADD: begin
                // add the current multiple when this factor bit is set
                if (r_m == 32'd0) begin
                    n_state = S_FIN;
                end else begin
                    if (r_m[0]) begin
                        n_acc = tadd_res;
                    end
                    n_state = S_MUL_DBL;
                end
            end
            S_MUL_DBL: begin
                n_cur   = tadd_res;
                n_m     = {1'b0, r_m[31:1]};
                n_state = S_MUL_ADD;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    case (r_phase)
                        2'd0: begin
                            // seconds done; next the per-divisor microsecond step
                            n_qs             = div_rsp.quot;
                            n_rs             = div_rsp.rem[19:0];
                            div_req.start    = 1'b1;
                            div_req.steps    = sutalu_pkg::DIV_STEPS_NARROW;
                            div_req.dividend = {sutalu_pkg::US_PER_SEC,
                                                {sutalu_pkg::DIV_PAD{1'b0}}};
                            div_req.divisor  = fac_mag;
                            n_phase          = 2'd1;
                        end
                        2'd1: begin
                            n_qk             = div_rsp.quot[19:0];
                            div_req.start    = 1'b1;
                            div_req.steps    = sutalu_pkg::DIV_STEPS_NARROW;
                            div_req.dividend = {r_tu, {sutalu_pkg::DIV_PAD{1'b0}}};
                            div_req.divisor  = fac_mag;
                            n_phase          = 2'd2;
                        end
                        default: begin
                            n_qu    = div_rsp.quot[19:0];
                            n_state = S_DIV_MUL;
                        end
                    endcase
                end
            end
            S_DIV_MUL: begin
                n_prod  = prod_full[19:0];
                n_state = S_DIV_SUM;
            end
            S_DIV_SUM: begin
                n_acc.s = r_qs;
                n_acc.u = r_prod + r_qu;
                n_state = S_FIN;
            end
            S_FIN: begin
                // apply the sign and post the word
                n_out_sec   = fin_val.s;
                n_out_usec  = fin_val.u;
                n_out_order = sutalu_pkg::ORDER_EQ;
                n_out_fits  = 1'b0;
                n_out_dz    = 1'b0;
                n_done      = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_a         <= n_a;
        r_b         <= n_b;
        r_fac       <= n_fac;
        r_acc       <= n_acc;
        r_cur       <= n_cur;
        r_m         <= n_m;
        r_neg       <= n_neg;
        r_tu        <= n_tu;
        r_qs        <= n_qs;
        r_rs        <= n_rs;
        r_qk        <= n_qk;
        r_qu        <= n_qu;
        r_prod      <= n_prod;
        r_phase     <= n_phase;
        r_out_sec   <= n_out_sec;
        r_out_usec  <= n_out_usec;
        r_out_order <= n_out_order;
        r_out_fits  <= n_out_fits;
        r_out_dz    <= n_out_dz;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_r_sec      = $signed(r_out_sec);
    assign o_r_usec     = r_out_usec;
    assign o_order      = r_out_order;
    assign o_fits_small = r_out_fits;
    assign o_div_zero   = r_out_dz;

    // checks
    `SUTALU_ASSERT_IMP(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)
    `SUTALU_ASSERT_NXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `SUTALU_ASSERT_NXT(a_done_one_cycle, i_clk, i_rst_n, o_done, !o_done)
    `SUTALU_ASSERT_IMP(a_div_zero_clears, i_clk, i_rst_n, o_done && o_div_zero,
        (o_r_sec == 32'sd0) && (o_r_usec == 20'd0) && (o_order == sutalu_pkg::ORDER_EQ))

endmodule

FILE: rtl/sutalu_tadd.sv
module sutalu_tadd (
    input  sutalu_pkg::t_tval i_x,
    input  sutalu_pkg::t_tval i_y,
    input  logic              i_sub,
    output sutalu_pkg::t_tval o_r
);

    logic [20:0] usum;
    logic [20:0] udif;
    logic        carry;
    logic        borrow;
    logic [20:0] ures;
    logic [31:0] yop;
    logic        cin;

    // microsecond sum and difference, one correction step each
    assign usum   = {1'b0, i_x.u} + {1'b0, i_y.u};
    assign udif   = {1'b0, i_x.u} - {1'b0, i_y.u};
    assign carry  = (usum >= sutalu_pkg::US_PER_SEC_W);
    assign borrow = udif[20];

    always_comb begin
        if (i_sub) begin
            ures = borrow ? (udif + sutalu_pkg::US_PER_SEC_W) : udif;
            yop  = ~i_y.s;
            cin  = ~borrow;
        end else begin
            ures = carry ? (usum - sutalu_pkg::US_PER_SEC_W) : usum;
            yop  = i_y.s;
            cin  = carry;
        end
    end

    // seconds: one adder, carry-in folds the borrow and the two's complement
    assign o_r.s = i_x.s + yop + {31'd0, cin};
    assign o_r.u = ures[19:0];

endmodule

FILE: rtl/sutalu_div.sv
module sutalu_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sutalu_pkg::t_div_req i_req,
    output sutalu_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    // one restoring step: shift in the next dividend bit, trial subtract
    assign shifted = {r_rem, r_q[31]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[30:0], ge};
                r_rem <= ge ? diff[31:0] : shifted[31:0];
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule
